### sv/dfpca_pkg.sv
// ----------------------------------------------------------------------------
// dfpca_pkg
// Shared constants, the reading conversion table and the controller/datapath
// command and status types of the dust frame parser and averager.
// ----------------------------------------------------------------------------
package dfpca_pkg;

    localparam int unsigned FRAME_LEN    = 7;
    localparam int unsigned SUM_W        = 21;
    localparam int unsigned PROD_W       = 30;
    localparam int unsigned DIV_STEPS    = 21;
    localparam int unsigned SEG_COUNT    = 13;

    localparam logic [7:0]  HEAD_MARK    = 8'hAA;
    localparam logic [7:0]  TAIL_MARK    = 8'hFF;
    localparam logic [7:0]  WINDOW_BYTES = 8'd128;
    localparam logic [4:0]  MAX_FRAMES   = 5'd31;
    localparam logic [2:0]  FILL_FULL    = 3'(FRAME_LEN);
    localparam logic [4:0]  DIV_LAST     = 5'(DIV_STEPS - 1);

    // Segment limits as raw reading thresholds: reading*5000 < T*1024 holds
    // exactly when reading < ceil(T*1024/5000).
    localparam logic [4:0] SEG_LIMIT [SEG_COUNT] = '{
        5'd9, 5'd10, 5'd11, 5'd12, 5'd12, 5'd14, 5'd15,
        5'd16, 5'd17, 5'd18, 5'd19, 5'd21, 5'd23
    };
    // Gain times five, so the value is (reading * mult) >> 10.
    localparam logic [13:0] SEG_MULT [SEG_COUNT] = '{
        14'd1000, 14'd2000, 14'd3000, 14'd3750, 14'd4500, 14'd5000, 14'd6250,
        14'd7000, 14'd8500, 14'd9000, 14'd9500, 14'd10000, 14'd11000
    };
    localparam logic [13:0] TOP_MULT     = 14'd15000;
    // Rounding offset of the lowest segment (8.5 scaled by 1024).
    localparam logic [13:0] LOW_OFFSET   = 14'd8704;

    typedef struct packed {
        logic shift_byte;   // take a byte into the window
        logic check;        // test the window, form the product
        logic acc;          // add the converted reading to the sum
        logic div_start;    // load the divider
        logic div_step;     // one quotient bit
        logic emit;         // load the output word, open a new period
    } dfpca_cmd_t;

    typedef struct packed {
        logic period_full;
        logic frame_hit;
        logic frame_room;
        logic no_frames;
        logic div_last;
        logic out_free;
    } dfpca_stat_t;

    // Product of the reading and its segment gain, scaled by 1024.
    function automatic logic [PROD_W-1:0] convert_product(input logic [15:0] adc);
        logic [13:0] mult;
        logic [13:0] offs;
        mult = TOP_MULT;
        offs = '0;
        for (int k = SEG_COUNT - 1; k >= 0; k--) begin
            if (adc < {11'd0, SEG_LIMIT[k]}) begin
                mult = SEG_MULT[k];
            end
        end
        if (adc < {11'd0, SEG_LIMIT[0]}) begin
            offs = LOW_OFFSET;
        end
        return PROD_W'(adc) * PROD_W'(mult) + PROD_W'(offs);
    endfunction

endpackage

### sv/dfpca_ctrl.sv
// ----------------------------------------------------------------------------
// dfpca_ctrl
// Sequencer: byte intake and frame check, accumulate, serial divide, emit.
// ----------------------------------------------------------------------------
module dfpca_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_tuser,
    input  dfpca_pkg::dfpca_stat_t  stat,
    output dfpca_pkg::dfpca_cmd_t   cmd
);
    import dfpca_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_take;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    if (s_tuser) begin
                        cmd.div_start = 1'b1;
                        state_next    = stat.no_frames ? ST_EMIT : ST_DIV;
                    end else if (!stat.period_full) begin
                        cmd.shift_byte = 1'b1;
                        state_next     = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = (stat.frame_hit && stat.frame_room) ? ST_ACC : ST_IDLE;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/dfpca_dpath.sv
// ----------------------------------------------------------------------------
// dfpca_dpath
// Frame window, reading conversion, period sum, restoring divider and the
// output register.
// ----------------------------------------------------------------------------
module dfpca_dpath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [7:0]              s_tdata,
    input  dfpca_pkg::dfpca_cmd_t   cmd,
    output dfpca_pkg::dfpca_stat_t  stat,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,
    output logic                    m_tuser
);
    import dfpca_pkg::*;

    logic [7:0]        win_reg [FRAME_LEN];
    logic [2:0]        fill_reg;
    logic [7:0]        pbytes_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [4:0]        frames_reg;
    logic [15:0]       last_avg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  quot_reg;
    logic [4:0]        rem_reg;
    logic [4:0]        cnt_reg;
    logic              out_valid_reg;
    logic [15:0]       out_pm_reg;
    logic [4:0]        out_count_reg;
    logic              out_flag_reg;

    logic [7:0]  csum;
    logic [15:0] conv;
    logic [5:0]  trial;
    logic        trial_ge;
    logic [15:0] avg_sat;

    assign csum = win_reg[1] + win_reg[2] + win_reg[3] + win_reg[4];

    assign stat.period_full = (pbytes_reg >= WINDOW_BYTES);
    assign stat.frame_hit   = (fill_reg == FILL_FULL) && (win_reg[0] == HEAD_MARK)
                              && (win_reg[FRAME_LEN-1] == TAIL_MARK) && (csum == win_reg[5]);
    assign stat.frame_room  = (frames_reg < MAX_FRAMES);
    assign stat.no_frames   = (frames_reg == 5'd0);
    assign stat.div_last    = (cnt_reg == DIV_LAST);
    assign stat.out_free    = !out_valid_reg || m_tready;

    // Drop the 1024 scale, clip to 16 bits.
    assign conv     = (|prod_reg[PROD_W-1:26]) ? 16'hFFFF : prod_reg[25:10];

    assign trial    = {rem_reg, quot_reg[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, frames_reg});
    assign avg_sat  = (|quot_reg[SUM_W-1:16]) ? 16'hFFFF : quot_reg[15:0];

    // Window contents matter only once the fill count reaches a full frame.
    always_ff @(posedge aclk) begin
        if (cmd.shift_byte) begin
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[FRAME_LEN-1] <= s_tdata;
        end
        if (cmd.check) begin
            prod_reg <= convert_product({win_reg[1], win_reg[2]});
        end
        if (cmd.div_start) begin
            quot_reg <= sum_reg;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            quot_reg <= {quot_reg[SUM_W-2:0], trial_ge};
            rem_reg  <= trial_ge ? 5'(trial - {1'b0, frames_reg}) : trial[4:0];
        end
        if (cmd.div_start) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (cmd.emit) begin
            out_pm_reg    <= stat.no_frames ? last_avg_reg : avg_sat;
            out_count_reg <= frames_reg;
            out_flag_reg  <= stat.no_frames;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            pbytes_reg    <= '0;
            sum_reg       <= '0;
            frames_reg    <= '0;
            last_avg_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                fill_reg   <= '0;
                pbytes_reg <= '0;
                sum_reg    <= '0;
                frames_reg <= '0;
                if (!stat.no_frames) begin
                    last_avg_reg <= avg_sat;
                end
            end else begin
                if (cmd.shift_byte) begin
                    pbytes_reg <= pbytes_reg + 8'd1;
                    if (fill_reg != FILL_FULL) begin
                        fill_reg <= fill_reg + 3'd1;
                    end
                end
                if (cmd.check && stat.frame_hit) begin
                    fill_reg <= '0;
                end
                if (cmd.acc) begin
                    sum_reg    <= sum_reg + {5'd0, conv};
                    frames_reg <= frames_reg + 5'd1;
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_count_reg, out_pm_reg};
    assign m_tuser  = out_flag_reg;

endmodule

### sv/dust_frame_parse_convert_average_top.sv
// ----------------------------------------------------------------------------
// dust_frame_parse_convert_average_top
// Dust sensor frame parser, reading converter and per-period averager.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry either a sensor byte (s_tuser = 0, byte in s_tdata) or
//   an end-of-period tick (s_tuser = 1). Bytes are scanned for the frame
//   AA d1 d2 d3 d4 sum FF; a good frame (at most 31 per period) converts
//   reading d1:d2 through the segment gain table and adds it to the period
//   sum. Only the first 128 bytes of a period count. A tick produces one
//   output word: the average (or, with no frames, the previous average, m_tuser = 1).
// Throughput: a byte holds the input through its check step, and through the
//   accumulate step when a frame is summed; a byte dropped because the period
//   is full is taken without either step. A tick holds the input through the
//   bit-serial divider, one quotient bit per cycle over 21 bits, and the emit
//   step, where its word is loaded into the output register. Ticks with no
//   frames skip the divider and go straight to the emit step.
// Reset: aresetn low clears the period, the window fill count and the held average;
//   the output word is dropped.
// Stall: a finished word waits in the output register while bytes keep
//   being taken; a further tick holds in its emit step until the word is
//   taken.
// ----------------------------------------------------------------------------
module dust_frame_parse_convert_average_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] pm_value, [20:16] frame_count, [23:21] zero
    output logic        m_tuser    // [0] no_frames
);
    import dfpca_pkg::*;

    dfpca_cmd_t  cmd;
    dfpca_stat_t stat;

    // Sequencer: owns the input handshake and steps the datapath.
    dfpca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: window, conversion, sum, divider and the output register.
    dfpca_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
